>>> sv/lxr_pkg.sv
// Shared types, character codes and keyword tables for the keyword/identifier lexer.
// No dependencies; imported by every module of the block.
package lxr_pkg;

  localparam int KeywordLenDef = 6;
  localparam int PosWidthDef   = 32;

  // Result queue depth: two slots per item plus room for the consumer to lag.
  localparam int ResDepth = 4;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_SYMBOL  = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_END     = 3'd5
  } tok_kind_e;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_IDENT = 2'd1;
  localparam logic [1:0] PEND_NUM   = 2'd2;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int NumKw = 4;
  localparam int KwMaxLen = 6;
  localparam int KW_LEN [NumKw] = '{2, 4, 5, 6};
  // Keyword text, first character in the low byte: if, else, while, return.
  localparam logic [NumKw-1:0][8*KwMaxLen-1:0] KW_TEXT = {
    48'h6e72_7574_6572,
    48'h0065_6c69_6877,
    48'h0000_6573_6c65,
    48'h0000_0000_6669
  };

  typedef struct packed {
    tok_kind_e   kind;
    logic [31:0] start;
    logic [15:0] length;
    logic [7:0]  ch;
    logic [1:0]  kw_idx;
    logic        last;
  } lxr_res_t;

  function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [3:0] pos);
    logic [8*KwMaxLen-1:0] txt;
    txt = KW_TEXT[idx];
    if (pos < 4'(KwMaxLen)) begin
      kw_char = txt[{pos[2:0], 3'b000} +: 8];
    end else begin
      kw_char = 8'h00;
    end
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_EQUAL || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

endpackage

>>> sv/lxr_core.sv
// Lexer state and per-item token logic: classifies one byte, updates the
// pending token and produces up to two tokens. Depends on lxr_pkg.
module lxr_core import lxr_pkg::*; #(
  parameter int KEYWORD_LEN = KeywordLenDef,
  parameter int POS_WIDTH   = PosWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              mode_i,
  input  logic [7:0]        char_i,
  output lxr_res_t [1:0]    res_o,
  output logic [1:0]        res_cnt_o
);

  logic [1:0]           pend_kind_q, pend_kind_d;
  logic [15:0]          pend_len_q, pend_len_d;
  logic [POS_WIDTH-1:0] pend_start_q, pend_start_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [7:0]           buf_q [KEYWORD_LEN];
  logic [7:0]           buf_d [KEYWORD_LEN];

  logic       c_alpha, c_digit, c_space, c_sym, cont;
  logic       flush_en, sec_en, kw_hit;
  logic [1:0] kw_idx;
  logic [NumKw-1:0] kw_match;
  lxr_res_t   fl_res, sec_res;

  // Keyword compare against the buffered head of the pending identifier
  always_comb begin
    for (int i = 0; i < NumKw; i++) begin
      kw_match[i] = (KW_LEN[i] <= KEYWORD_LEN) && (pend_len_q == 16'(KW_LEN[i]));
      for (int j = 0; j < KEYWORD_LEN; j++) begin
        if (j < KW_LEN[i] && buf_q[j] != kw_char(2'(i), 4'(j))) begin
          kw_match[i] = 1'b0;
        end
      end
    end
    kw_hit = |kw_match;
    priority if (kw_match[0]) kw_idx = 2'd0;
    else if (kw_match[1]) kw_idx = 2'd1;
    else if (kw_match[2]) kw_idx = 2'd2;
    else if (kw_match[3]) kw_idx = 2'd3;
    else kw_idx = 2'd0;
  end

  always_comb begin
    c_alpha = is_alpha(char_i);
    c_digit = is_digit(char_i);
    c_space = is_space(char_i);
    c_sym   = is_symbol(char_i);
    cont = (mode_i == MODE_CHAR) &&
           ((pend_kind_q == PEND_IDENT && (c_alpha || c_digit || char_i == CH_UNDER)) ||
            (pend_kind_q == PEND_NUM && c_digit));
    flush_en = (pend_kind_q != PEND_NONE) && !cont;
    sec_en   = (mode_i == MODE_END) || (!cont && !c_alpha && !c_digit && !c_space);

    fl_res.kind   = (pend_kind_q == PEND_NUM) ? KIND_NUMBER :
                    (kw_hit ? KIND_KEYWORD : KIND_IDENT);
    fl_res.start  = 32'(pend_start_q);
    fl_res.length = pend_len_q;
    fl_res.ch     = buf_q[0];
    fl_res.kw_idx = (pend_kind_q == PEND_IDENT && kw_hit) ? kw_idx : 2'd0;
    fl_res.last   = !sec_en;

    sec_res.start  = 32'(pos_q);
    sec_res.kw_idx = 2'd0;
    sec_res.last   = 1'b1;
    if (mode_i == MODE_END) begin
      sec_res.kind   = KIND_END;
      sec_res.length = 16'd0;
      sec_res.ch     = 8'h00;
    end else begin
      sec_res.kind   = c_sym ? KIND_SYMBOL : KIND_UNKNOWN;
      sec_res.length = 16'd1;
      sec_res.ch     = char_i;
    end

    res_o[0]  = flush_en ? fl_res : sec_res;
    res_o[1]  = sec_res;
    res_cnt_o = {1'b0, flush_en} + {1'b0, sec_en};
  end

  always_comb begin
    pend_kind_d  = pend_kind_q;
    pend_len_d   = pend_len_q;
    pend_start_d = pend_start_q;
    pos_d        = pos_q;
    buf_d        = buf_q;
    if (fire_i) begin
      if (mode_i == MODE_END) begin
        pend_kind_d  = PEND_NONE;
        pend_len_d   = 16'd0;
        pend_start_d = '0;
        pos_d        = '0;
      end else begin
        pos_d = pos_q + POS_WIDTH'(1);
        if (cont) begin
          for (int j = 0; j < KEYWORD_LEN; j++) begin
            if (pend_len_q == 16'(j)) begin
              buf_d[j] = char_i;
            end
          end
          if (pend_len_q != LEN_MAX) begin
            pend_len_d = pend_len_q + 16'd1;
          end
        end else if (c_alpha || c_digit) begin
          pend_kind_d  = c_alpha ? PEND_IDENT : PEND_NUM;
          pend_len_d   = 16'd1;
          pend_start_d = pos_q;
          buf_d[0]     = char_i;
        end else begin
          pend_kind_d = PEND_NONE;
          pend_len_d  = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_kind_q  <= PEND_NONE;
      pend_len_q   <= 16'd0;
      pend_start_q <= '0;
      pos_q        <= '0;
    end else begin
      pend_kind_q  <= pend_kind_d;
      pend_len_q   <= pend_len_d;
      pend_start_q <= pend_start_d;
      pos_q        <= pos_d;
    end
  end

  // buffer bytes are only read below the pending length, so no reset needed
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

>>> sv/lxr_fifo.sv
// Token result queue: takes up to two tokens per cycle, hands out one per
// output handshake. Depends on lxr_pkg.
module lxr_fifo import lxr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lxr_res_t [1:0]  wr_data_i,
  input  logic [1:0]      wr_cnt_i,
  output logic            space2_o,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output lxr_res_t        rd_data_o
);

  localparam int PtrW = $clog2(ResDepth);
  localparam int CntW = $clog2(ResDepth + 1);

  lxr_res_t        mem_q [ResDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_fire;

  assign rd_valid_o = cnt_q != '0;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign space2_o   = cnt_q <= CntW'(ResDepth - 2);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(rd_fire);
    cnt_d    = cnt_q + CntW'(wr_cnt_i) - CntW'(rd_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_data_i[0];
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= wr_data_i[1];
    end
  end

endmodule

>>> sv/keyword_identifier_lexer.sv
// Streaming lexer for keywords (if, else, while, return), identifiers, numbers
// and single-character symbols. One byte is taken per cycle while in_ready_o
// is high; the byte's tokens are written into a 4-entry result queue in the
// same cycle and leave the registered queue in order, one per output handshake. A byte
// that ends a pending identifier or number and is itself a symbol or unknown
// yields two tokens, as does the end marker with a token pending; in_ready_o
// is high whenever the queue has two free slots, so with a consumer that
// takes a token every cycle the input sustains one byte per cycle.
// Depends on lxr_pkg, lxr_core and lxr_fifo.
module keyword_identifier_lexer import lxr_pkg::*; #(
  parameter int KEYWORD_LEN = KeywordLenDef,
  parameter int POS_WIDTH   = PosWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  char_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [31:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  token_char_o,
  output logic [1:0]  keyword_index_o,
  output logic        last_result_o
);

  logic           in_fire;
  lxr_res_t [1:0] res;
  logic [1:0]     res_cnt;
  lxr_res_t       head;

  assign in_fire = in_valid_i && in_ready_o;

  lxr_core #(
    .KEYWORD_LEN(KEYWORD_LEN),
    .POS_WIDTH  (POS_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .mode_i   (mode_i),
    .char_i   (char_byte_i),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  lxr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (res),
    .wr_cnt_i  (in_fire ? res_cnt : 2'd0),
    .space2_o  (in_ready_o),
    .rd_valid_o(out_valid_o),
    .rd_ready_i(out_ready_i),
    .rd_data_o (head)
  );

  assign token_kind_o    = head.kind;
  assign token_start_o   = head.start;
  assign token_length_o  = head.length;
  assign token_char_o    = head.ch;
  assign keyword_index_o = head.kw_idx;
  assign last_result_o   = head.last;

  // input only stalls while tokens are waiting
  a_stall_has_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o) else $error("input stalled with empty queue");

  // end marker always produces a token on the next cycle
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_i == MODE_END |=> out_valid_o) else $error("end marker lost");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_END |-> last_result_o && token_length_o == 16'd0)
    else $error("end token malformed");

  a_kw_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_KEYWORD |->
      token_length_o >= 16'd2 && token_length_o <= 16'd6)
    else $error("keyword with bad length");

endmodule

>>> sim/tb_keyword_identifier_lexer.sv
// Testbench for keyword_identifier_lexer: directed and random byte streams are
// driven and each token is checked against a predictor kept in step here.
// Depends on lxr_pkg and the keyword_identifier_lexer RTL.
`timescale 1ns / 100ps

module tb_keyword_identifier_lexer;
  import lxr_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int          MaxReports = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        mode_i      = MODE_CHAR;
  logic [7:0]  char_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic [31:0] token_start_o;
  logic [15:0] token_length_o;
  logic [7:0]  token_char_o;
  logic [1:0]  keyword_index_o;
  logic        last_result_o;

  keyword_identifier_lexer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .char_byte_i    (char_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .token_char_o   (token_char_o),
    .keyword_index_o(keyword_index_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Lexer shadow state
  lxr_res_t    exp_tokens [$];
  logic [1:0]  word_kind;
  logic [7:0]  word_buf [KeywordLenDef];
  logic [15:0] word_len;
  logic [31:0] word_start;
  logic [31:0] stream_pos;

  string      kw_words [NumKw] = '{"if", "else", "while", "return"};
  logic [7:0] sym_chars [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL,
                                 CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};

  int          err_cnt      = 0;
  int          items_sent   = 0;
  int unsigned cycle_cnt    = 0;
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int          hold_req     = 0;

  function automatic bit ch_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit ch_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit ch_symbol(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    foreach (sym_chars[i]) if (sym_chars[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic void clear_word();
    word_kind  = PEND_NONE;
    word_len   = '0;
    word_start = '0;
    foreach (word_buf[i]) word_buf[i] = 8'h00;
  endfunction

  function automatic void push_token(input tok_kind_e kind, input logic [31:0] start,
                                     input logic [15:0] len, input logic [7:0] ch,
                                     input logic [1:0] kwi);
    lxr_res_t tok;
    tok.kind   = kind;
    tok.start  = start;
    tok.length = len;
    tok.ch     = ch;
    tok.kw_idx = kwi;
    tok.last   = 1'b0;
    exp_tokens.push_back(tok);
  endfunction

  // Emit the pending identifier or number, resolving keywords.
  function automatic void flush_word();
    tok_kind_e  kind;
    logic [1:0] kwi;
    bit         hit;
    if (word_kind == PEND_NONE) return;
    kind = (word_kind == PEND_NUM) ? KIND_NUMBER : KIND_IDENT;
    kwi  = 2'd0;
    if (word_kind == PEND_IDENT) begin
      for (int i = 0; i < NumKw; i++) begin
        if (kind == KIND_IDENT && int'(word_len) == kw_words[i].len() &&
            kw_words[i].len() <= KeywordLenDef) begin
          hit = 1'b1;
          for (int j = 0; j < kw_words[i].len(); j++)
            if (word_buf[j] != kw_words[i][j]) hit = 1'b0;
          if (hit) begin
            kind = KIND_KEYWORD;
            kwi  = 2'(i);
          end
        end
      end
    end
    push_token(kind, word_start, word_len, word_buf[0], kwi);
    clear_word();
  endfunction

  function automatic void lex_step(input logic m, input logic [7:0] c);
    int n_before;
    n_before = exp_tokens.size();
    if (m == MODE_END) begin
      flush_word();
      push_token(KIND_END, stream_pos, 16'd0, 8'h00, 2'd0);
      clear_word();
      stream_pos = '0;
    end else begin
      if ((word_kind == PEND_IDENT && (ch_letter(c) || ch_numeral(c) || c == CH_UNDER)) ||
          (word_kind == PEND_NUM && ch_numeral(c))) begin
        if (word_len < 16'(KeywordLenDef)) word_buf[word_len] = c;
        if (word_len != LEN_MAX) word_len++;
      end else begin
        flush_word();
        if (ch_letter(c) || ch_numeral(c)) begin
          word_kind   = ch_letter(c) ? PEND_IDENT : PEND_NUM;
          word_start  = stream_pos;
          word_len    = 16'd1;
          word_buf[0] = c;
        end else if (ch_symbol(c)) begin
          push_token(KIND_SYMBOL, stream_pos, 16'd1, c, 2'd0);
        end else if (!ch_blank(c)) begin
          push_token(KIND_UNKNOWN, stream_pos, 16'd1, c, 2'd0);
        end
      end
      stream_pos = stream_pos + 32'd1;
    end
    if (exp_tokens.size() > n_before) exp_tokens[exp_tokens.size() - 1].last = 1'b1;
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(input logic m, input logic [7:0] c);
    while (send_idle_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    char_byte_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    lex_step(m, c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(MODE_CHAR, s[i]);
  endtask

  task automatic send_end();
    send_item(MODE_END, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_tokens.size() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
  endfunction

  function automatic logic [7:0] rand_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (ch_letter(c) || ch_numeral(c) || ch_blank(c) || ch_symbol(c));
    return c;
  endfunction

  // Keyword or a near miss: exact, capitalized, one char longer, one char shorter.
  task automatic send_keyword_like();
    string      w;
    int         variant;
    int         n;
    logic [7:0] c;
    w       = kw_words[$urandom_range(NumKw - 1)];
    variant = $urandom_range(5);
    n       = (variant == 3) ? w.len() - 1 : w.len();
    for (int i = 0; i < n; i++) begin
      c = w[i];
      if (variant == 1 && i == 0) c = c - 8'h20;
      send_item(MODE_CHAR, c);
    end
    if (variant == 2) send_item(MODE_CHAR, rand_word_char());
  endtask

  task automatic send_random_token();
    int r;
    r = $urandom_range(99);
    if (r < 22) begin
      send_keyword_like();
    end else if (r < 45) begin
      send_item(MODE_CHAR, rand_letter());
      repeat ($urandom_range(9)) send_item(MODE_CHAR, rand_word_char());
    end else if (r < 58) begin
      repeat ($urandom_range(7, 1)) send_item(MODE_CHAR, 8'("0" + $urandom_range(9)));
    end else if (r < 72) begin
      send_item(MODE_CHAR, sym_chars[$urandom_range(9)]);
    end else if (r < 80) begin
      send_item(MODE_CHAR, rand_blank());
    end else if (r < 88) begin
      send_item(MODE_CHAR, rand_unknown());
    end else if (r < 92) begin
      send_end();
    end else begin
      send_item(MODE_CHAR, 8'($urandom_range(255)));
    end
    if ($urandom_range(1)) send_item(MODE_CHAR, rand_blank());
  endtask

  task automatic test_keywords();
    send_text("if\relse;while(return)");
    send_end();
    wait_drained();
  endtask

  // Leading underscore, extreme bytes, number cut by underscore, long identifier,
  // end with a token pending and end with nothing pending.
  task automatic test_edge_tokens();
    send_text("_a");
    send_item(MODE_CHAR, 8'h00);
    send_item(MODE_CHAR, 8'h80);
    send_item(MODE_CHAR, 8'hFF);
    send_text("9_returned");
    send_end();
    send_end();
    wait_drained();
  endtask

  // Receiver stalls long while the sender keeps offering two-token pairs.
  task automatic test_backpressure();
    send_idle_on = 1'b0;
    hold_req     = 120;
    repeat (40) begin
      send_item(MODE_CHAR, rand_letter());
      send_item(MODE_CHAR, sym_chars[$urandom_range(9)]);
    end
    send_end();
    wait_drained();
    send_idle_on = 1'b1;
  endtask

  task automatic test_random_text(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_token();
    send_end();
    wait_drained();
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Token checker and receiver ready generation
  initial begin
    lxr_res_t want;
    int       hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (exp_tokens.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: unexpected token: expected none, actual kind %0d start %0h",
                     $time, token_kind_o, token_start_o);
        end else begin
          want = exp_tokens.pop_front();
          check_field("token_kind", want.kind, token_kind_o);
          check_field("token_start", want.start, token_start_o);
          check_field("token_length", want.length, token_length_o);
          check_field("token_char", want.ch, token_char_o);
          check_field("keyword_index", want.kw_idx, keyword_index_o);
          check_field("last_result", want.last, last_result_o);
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(recv_idle_on && $urandom_range(99) < 33);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d tokens outstanding",
               $time, cycle_cnt, exp_tokens.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clear_word();
    stream_pos = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_keywords();
    test_edge_tokens();
    test_backpressure();

    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random_text(400);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_random_text(1380);

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> keyword_identifier_lexer.f
sv/lxr_pkg.sv
sv/lxr_core.sv
sv/lxr_fifo.sv
sv/keyword_identifier_lexer.sv
sim/tb_keyword_identifier_lexer.sv
